FILE: sv/utf8_to_latin1_decoder_assert.svh
// assertion macros for the utf8 to latin-1 decoder checker
`ifndef UTF8_TO_LATIN1_DECODER_ASSERT_SVH
`define UTF8_TO_LATIN1_DECODER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define U2L_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define U2L_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/u2l_pkg.sv
// shared types, constants and fold table of the utf8 to latin-1 decoder
`default_nettype none

package u2l_pkg;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INVALID    = 2'd1,
        ST_OUTSIDE    = 2'd2,
        ST_INCOMPLETE = 2'd3
    } u2l_status_t;

    typedef enum logic [1:0] {
        CFG_UTF8_ENABLE = 2'd0,
        CFG_WIDE_OUTPUT = 2'd1,
        CFG_FOLD_ENABLE = 2'd2
    } u2l_cfg_idx_t;

    localparam int CODE_W  = 21;
    localparam int LEN_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CODE_W-1:0] LATIN1_MAX = 21'h0000FF;
    localparam logic [CODE_W-1:0] CODE_BOM   = 21'h00FEFF;
    localparam logic [7:0]        CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } u2l_in_t;

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic [LEN_W-1:0]  seq_length;
        u2l_status_t       status;
    } u2l_out_t;

    typedef struct packed {
        logic utf8_enable;
        logic wide_output;
        logic fold_enable;
    } u2l_cfg_t;

    typedef struct packed {
        logic     has;
        u2l_out_t data;
    } u2l_res_t;

    // latin-1 lookalikes of punctuation, space and symbol codes, zero when the code has none
    function automatic logic [7:0] u2l_fold(input logic [CODE_W-1:0] c);
        logic [7:0] f;
        f = 8'h00;
        if (c >= 21'h00201C && c <= 21'h00201F) begin
            f = 8'h22;
        end else if (c >= 21'h002018 && c <= 21'h00201B) begin
            f = 8'h27;
        end else if (c >= 21'h002010 && c <= 21'h002015) begin
            f = 8'h2D;
        end else if (c >= 21'h002000 && c <= 21'h00200A) begin
            f = 8'h20;
        end else if (c == 21'h002022) begin
            f = 8'hB7;
        end else if (c == 21'h0020AC) begin
            f = 8'h80;
        end else if (c == 21'h002122) begin
            f = 8'h99;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: sv/u2l_in_reg.sv
// input register stage of the decoder
`default_nettype none

module u2l_in_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire u2l_pkg::u2l_in_t s_data,
    output logic                  q_valid,
    output u2l_pkg::u2l_in_t      q_data,
    input  wire logic             q_pop
);
    import u2l_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    u2l_in_t  data_reg;

    assign s_ready = !valid_reg || q_pop;
    assign q_valid = valid_reg;
    assign q_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (q_pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/u2l_decode.sv
// sequence state and single-pass decode of one byte
`default_nettype none

module u2l_decode (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire u2l_pkg::u2l_cfg_t cfg,
    input  wire logic             in_valid,
    input  wire u2l_pkg::u2l_in_t in_data,
    input  wire logic             out_ready,
    output logic                  fire,
    output u2l_pkg::u2l_res_t     res
);
    import u2l_pkg::*;

    logic [1:0]        pend_reg;
    logic [1:0]        pend_next;
    logic [LEN_W-1:0]  seq_reg;
    logic [LEN_W-1:0]  seq_next;
    logic [CODE_W-1:0] acc_reg;
    logic [CODE_W-1:0] acc_next;

    logic [7:0]        b;
    logic              eot;
    logic [CODE_W-1:0] merged;
    logic [7:0]        folded;
    u2l_res_t          r;

    assign b   = in_data.data_byte;
    assign eot = in_data.end_of_text;

    always_comb begin
        case (pend_reg)
            2'd3:    merged = acc_reg | {3'b000, b[5:0], 12'h000};
            2'd2:    merged = acc_reg | {9'h000, b[5:0], 6'h00};
            default: merged = acc_reg | {15'h0000, b[5:0]};
        endcase
    end

    assign folded = cfg.fold_enable ? u2l_fold(merged) : 8'h00;

    always_comb begin
        r.has             = 1'b0;
        r.data.char_code  = '0;
        r.data.seq_length = 3'd1;
        r.data.status     = ST_OK;
        pend_next         = pend_reg;
        seq_next          = seq_reg;
        acc_next          = acc_reg;

        if (!cfg.utf8_enable) begin
            r.has            = 1'b1;
            r.data.char_code = {13'h0000, b};
            pend_next        = 2'd0;
            seq_next         = '0;
            acc_next         = '0;
        end else if (pend_reg == 2'd0) begin
            if (!b[7]) begin
                r.has            = 1'b1;
                r.data.char_code = {13'h0000, b};
            end else if (!b[6]) begin
                r.has            = 1'b1;
                r.data.char_code = (b[5:0] != 6'h00) ? {15'h0000, b[5:0]}
                                                     : {13'h0000, b};
            end else if (!b[5]) begin
                acc_next  = {10'h000, b[4:0], 6'h00};
                seq_next  = 3'd2;
                pend_next = 2'd1;
            end else if (!b[4]) begin
                acc_next  = {5'h00, b[3:0], 12'h000};
                seq_next  = 3'd3;
                pend_next = 2'd2;
            end else if (!b[3]) begin
                acc_next  = {b[2:0], 18'h00000};
                seq_next  = 3'd4;
                pend_next = 2'd3;
            end else begin
                r.has         = 1'b1;
                r.data.status = ST_INVALID;
            end
            // lead byte on the last transfer of the text
            if (eot && !r.has) begin
                r.has         = 1'b1;
                r.data.status = ST_INCOMPLETE;
                pend_next     = 2'd0;
                seq_next      = '0;
                acc_next      = '0;
            end
        end else begin
            pend_next = pend_reg - 2'd1;
            acc_next  = merged;
            if (pend_reg == 2'd1) begin
                r.has             = 1'b1;
                r.data.seq_length = seq_reg;
                pend_next         = 2'd0;
                seq_next          = '0;
                acc_next          = '0;
                if (merged == '0) begin
                    r.data.status = ST_INVALID;
                end else if (cfg.wide_output || merged <= LATIN1_MAX) begin
                    r.data.char_code = merged;
                end else if (merged == CODE_BOM) begin
                    r.data.char_code = {13'h0000, CHAR_SPACE};
                end else if (folded != 8'h00) begin
                    r.data.char_code = {13'h0000, folded};
                end else begin
                    r.data.status = ST_OUTSIDE;
                end
            end else if (eot) begin
                r.has             = 1'b1;
                r.data.status     = ST_INCOMPLETE;
                r.data.seq_length = seq_reg - {1'b0, pend_reg - 2'd1};
                pend_next         = 2'd0;
                seq_next          = '0;
                acc_next          = '0;
            end
        end
    end

    assign res  = r;
    assign fire = in_valid && (!r.has || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
            seq_reg  <= '0;
            acc_reg  <= '0;
        end else if (fire) begin
            pend_reg <= pend_next;
            seq_reg  <= seq_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/u2l_out_reg.sv
// result register stage of the decoder
`default_nettype none

module u2l_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire u2l_pkg::u2l_out_t load_data,
    output logic                   load_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output u2l_pkg::u2l_out_t      m_data
);
    import u2l_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    u2l_out_t data_reg;

    assign load_ready = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign m_data     = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/utf8_to_latin1_decoder.sv
// top level of the utf8 to latin-1 decoder
//
//   channel  prefix  direction  payload
//   input    s_      in         u2l_in_t  (data_byte, end_of_text)
//   result   m_      out        u2l_out_t (char_code, seq_length, status)
//   config   cfg_    in         cfg_index, cfg_data
//
// one byte accepted per cycle unless a stalled result register holds it back; a result is offered
// once its last byte has moved from the input register to the result register
// bytes that only extend a pending sequence give no result and never stall
// aresetn is synchronous; it empties both registers and drops any pending sequence
// a stalled result register holds back only bytes that would produce a result
`default_nettype none

module utf8_to_latin1_decoder (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire u2l_pkg::u2l_in_t         s_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output u2l_pkg::u2l_out_t             m_data,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [u2l_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                     cfg_data
);
    import u2l_pkg::*;

    u2l_cfg_t cfg_reg;
    u2l_cfg_t cfg_next;

    logic     q_valid;
    u2l_in_t  q_data;
    logic     fire;
    logic     load_ready;
    u2l_res_t res;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_UTF8_ENABLE: cfg_next.utf8_enable = cfg_data;
                CFG_WIDE_OUTPUT: cfg_next.wide_output = cfg_data;
                CFG_FOLD_ENABLE: cfg_next.fold_enable = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.utf8_enable <= 1'b1;
            cfg_reg.wide_output <= 1'b0;
            cfg_reg.fold_enable <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    u2l_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (fire)
    );

    u2l_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (q_valid),
        .in_data   (q_data),
        .out_ready (load_ready),
        .fire      (fire),
        .res       (res)
    );

    u2l_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire && res.has),
        .load_data  (res.data),
        .load_ready (load_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

FILE: sv/u2l_checker.sv
// port-level checks of the utf8 to latin-1 decoder, bound to the top level
`default_nettype none

`include "utf8_to_latin1_decoder_assert.svh"

module u2l_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire u2l_pkg::u2l_out_t m_data
);
    import u2l_pkg::*;

    // stalled result holds
    `U2L_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "stalled result changed")
    // failed status carries no code
    `U2L_ASSERT_NOW(a_fail_zero_code, aclk, aresetn,
        m_valid && m_data.status != ST_OK, m_data.char_code == '0, "nonzero code on failure")
    // every transfer consumes one to four bytes
    `U2L_ASSERT_NOW(a_len_range, aclk, aresetn, m_valid,
        m_data.seq_length != 3'd0 && m_data.seq_length <= 3'd4, "bad sequence length")
    // truncated sequence never reaches full length
    `U2L_ASSERT_NOW(a_incomplete_len, aclk, aresetn,
        m_valid && m_data.status == ST_INCOMPLETE, m_data.seq_length <= 3'd3,
        "incomplete sequence too long")

endmodule

bind utf8_to_latin1_decoder u2l_checker u_u2l_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_utf8_to_latin1_decoder.sv
// testbench of the utf8 to latin-1 decoder: directed and random byte streams against a behavioral decoder
`default_nettype none

module tb_utf8_to_latin1_decoder;
    import u2l_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    u2l_in_t              s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    u2l_out_t             m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_UTF8_ENABLE;
    logic                 cfg_data  = 1'b0;

    u2l_in_t  text_bytes[$];
    u2l_out_t expected_chars[$];
    int       bytes_queued   = 0;
    int       bytes_taken    = 0;
    int       mismatches     = 0;
    int       quiet_cycles   = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;

    // decoder state and register copy
    u2l_cfg_t          decode_cfg = '{utf8_enable: 1'b1, wide_output: 1'b0,
                                      fold_enable: 1'b1};
    logic [1:0]        pend       = '0;
    logic [LEN_W-1:0]  seq_len    = '0;
    logic [CODE_W-1:0] acc        = '0;

    utf8_to_latin1_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void decode_byte(input u2l_in_t item);
        logic [7:0]        b;
        int                ones;
        logic [CODE_W-1:0] lead_bits;
        logic [CODE_W-1:0] cont_bits;
        logic [CODE_W-1:0] code;
        logic [7:0]        lookalike;
        u2l_out_t          r;
        b = item.data_byte;
        r.char_code  = '0;
        r.seq_length = 3'd1;
        r.status     = ST_OK;
        if (!decode_cfg.utf8_enable) begin
            pend = '0;
            seq_len = '0;
            acc = '0;
            r.char_code = {13'h0000, b};
            expected_chars.push_back(r);
            return;
        end
        if (pend == 0) begin
            ones = 0;
            while (ones < 8 && b[7 - ones]) ones++;
            if (ones == 0) begin
                r.char_code = {13'h0000, b};
            end else if (ones > 4) begin
                r.status = ST_INVALID;
            end else if (ones == 1) begin
                r.char_code = (b[5:0] != 6'h00) ? {15'h0000, b[5:0]} : {13'h0000, b};
            end else if (item.end_of_text) begin
                r.status = ST_INCOMPLETE;
            end else begin
                lead_bits = {13'h0000, b & (8'h7F >> ones)};
                acc = lead_bits << ((ones - 1) * 6);
                seq_len = 3'(ones);
                pend = 2'(ones - 1);
                return;
            end
            expected_chars.push_back(r);
            return;
        end
        cont_bits = {15'h0000, b[5:0]};
        acc = acc | (cont_bits << ((pend - 1) * 6));
        pend = pend - 2'd1;
        if (pend == 0) begin
            code = acc;
            r.seq_length = seq_len;
            seq_len = '0;
            acc = '0;
            if (code == 0) begin
                r.status = ST_INVALID;
            end else if (decode_cfg.wide_output || code <= LATIN1_MAX) begin
                r.char_code = code;
            end else if (code == CODE_BOM) begin
                r.char_code = {13'h0000, CHAR_SPACE};
            end else begin
                lookalike = 8'h00;
                if (decode_cfg.fold_enable) begin
                    if (code >= 21'h201C && code <= 21'h201F) lookalike = 8'h22;
                    else if (code >= 21'h2018 && code <= 21'h201B) lookalike = 8'h27;
                    else if (code >= 21'h2010 && code <= 21'h2015) lookalike = 8'h2D;
                    else if (code >= 21'h2000 && code <= 21'h200A) lookalike = 8'h20;
                    else if (code == 21'h2022) lookalike = 8'hB7;
                    else if (code == 21'h20AC) lookalike = 8'h80;
                    else if (code == 21'h2122) lookalike = 8'h99;
                end
                if (lookalike != 0) r.char_code = {13'h0000, lookalike};
                else r.status = ST_OUTSIDE;
            end
        end else if (item.end_of_text) begin
            r.seq_length = seq_len - {1'b0, pend};
            r.status = ST_INCOMPLETE;
            pend = '0;
            seq_len = '0;
            acc = '0;
        end else begin
            return;
        end
        expected_chars.push_back(r);
    endfunction

    // input transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (text_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= text_bytes.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        u2l_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decode_byte(s_data);
                bytes_taken++;
            end
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected result, expected none, %s %h len %0d status %0d",
                             $time, "actual code", m_data.char_code, m_data.seq_length,
                             m_data.status);
                    mismatches++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_data.char_code !== want.char_code) begin
                        $display("%0t: char_code mismatch, expected %h actual %h",
                                 $time, want.char_code, m_data.char_code);
                        mismatches++;
                    end
                    if (m_data.seq_length !== want.seq_length) begin
                        $display("%0t: seq_length mismatch, expected %0d actual %0d",
                                 $time, want.seq_length, m_data.seq_length);
                        mismatches++;
                    end
                    if (m_data.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, m_data.status);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_UTF8_ENABLE: decode_cfg.utf8_enable = val;
            CFG_WIDE_OUTPUT: decode_cfg.wide_output = val;
            CFG_FOLD_ENABLE: decode_cfg.fold_enable = val;
            default: ;
        endcase
    endtask

    task automatic set_mode(input logic utf8, input logic wide, input logic fold);
        write_reg(CFG_UTF8_ENABLE, utf8);
        write_reg(CFG_WIDE_OUTPUT, wide);
        write_reg(CFG_FOLD_ENABLE, fold);
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic eot);
        u2l_in_t item;
        item.data_byte   = b;
        item.end_of_text = eot;
        text_bytes.push_back(item);
        bytes_queued++;
    endtask

    // encodes code in len bytes, sends the first keep of them
    task automatic queue_sequence(input logic [CODE_W-1:0] code, input int len,
                                  input int keep, input logic eot);
        logic [7:0] b;
        for (int i = 0; i < keep; i++) begin
            if (len == 1) begin
                b = {1'b0, code[6:0]};
            end else if (i == 0) begin
                b = (8'hFF << (8 - len)) | (8'(code >> (6 * (len - 1))) & (8'h7F >> len));
            end else begin
                b = {2'b10, 6'(code >> (6 * (len - 1 - i)))};
                // continuation prefix is not checked
                if ($urandom_range(7) == 0) b[7:6] = 2'($urandom);
            end
            queue_byte(b, eot && (i == keep - 1));
        end
    endtask

    task automatic queue_random_text(input int count);
        int                start;
        int                len;
        int                keep;
        logic [CODE_W-1:0] code;
        logic              eot;
        start = bytes_queued;
        while (bytes_queued - start < count) begin
            if ($urandom_range(99) < 25) begin
                queue_byte(8'($urandom), $urandom_range(7) == 0);
            end else begin
                len = $urandom_range(1, 4);
                case (len)
                    1: code = 21'($urandom_range(8'h7F));
                    2: code = 21'($urandom_range(21'h7FF));
                    3: begin
                        case ($urandom_range(2))
                            0: code = 21'($urandom_range(21'hFFFF));
                            1: code = 21'($urandom_range(21'h1FFE, 21'h2124));
                            default: begin
                                case ($urandom_range(3))
                                    0: code = CODE_BOM;
                                    1: code = 21'h2022;
                                    2: code = 21'h20AC;
                                    default: code = 21'h2122;
                                endcase
                            end
                        endcase
                    end
                    default: code = 21'($urandom_range(21'h1FFFFF));
                endcase
                // overlong zero
                if ($urandom_range(15) == 0) code = '0;
                keep = len;
                if (len > 1 && $urandom_range(5) == 0) keep = $urandom_range(1, len - 1);
                eot = (keep < len) ? 1'($urandom_range(1)) : ($urandom_range(15) == 0);
                queue_sequence(code, len, keep, eot);
            end
        end
    endtask

    task automatic wait_drain;
        while (bytes_taken != bytes_queued || expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct  = 10;
        recv_stall_pct = 69;
        // reset register values
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hF8, 1'b0);
        queue_sequence(21'h0000E9, 2, 2, 1'b0);
        queue_sequence(21'h000000, 2, 2, 1'b0);
        queue_sequence(CODE_BOM, 3, 3, 1'b0);
        queue_sequence(21'h00201C, 3, 3, 1'b0);
        queue_sequence(21'h0020AC, 3, 3, 1'b0);
        queue_sequence(21'h01F600, 4, 4, 1'b0);
        queue_sequence(21'h002013, 3, 1, 1'b1);
        queue_sequence(21'h002013, 3, 2, 1'b1);
        queue_random_text(250);
        wait_drain();

        set_mode(1'b1, 1'b0, 1'b0);
        queue_random_text(275);
        wait_drain();

        send_idle_pct  = 69;
        recv_stall_pct = 10;
        write_reg(CFG_UNUSED_IDX, 1'b1);
        set_mode(1'b1, 1'b1, 1'b1);
        queue_random_text(275);
        wait_drain();

        set_mode(1'b0, 1'b0, 1'b1);
        queue_random_text(275);
        wait_drain();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_mode(1'b1, 1'b1, 1'b0);
        queue_random_text(275);
        wait_drain();

        set_mode(1'b1, 1'b0, 1'b1);
        queue_random_text(275);
        wait_drain();

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: utf8_to_latin1_decoder.f
+incdir+sv
sv/u2l_pkg.sv
sv/u2l_in_reg.sv
sv/u2l_decode.sv
sv/u2l_out_reg.sv
sv/utf8_to_latin1_decoder.sv
sv/u2l_checker.sv
tb/sv/tb_utf8_to_latin1_decoder.sv
